// ===== hw/rtl/cau_pkg.sv =====
// Complex arithmetic unit: shared widths, opcodes, state and command types.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package cau_pkg;

  localparam int DW      = 32;             // word width, signed Q8.24
  localparam int FW      = 24;             // fractional bits
  localparam int MAX_EXP = 16;
  localparam int CMD_W   = 3;
  localparam int EXP_W   = 5;
  localparam int STS_W   = 2;
  localparam int CNT_W   = $clog2(DW);
  localparam int REM_W   = $clog2(MAX_EXP);
  localparam int ACC_W   = 2 * DW + 2;
  localparam int DEN_W   = 2 * DW;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PS_RR,
    PS_II,
    PS_RI,
    PS_IR,
    PS_YRR,
    PS_YII
  } prod_sel_e;

  typedef enum logic [1:0] {
    AD_RE,
    AD_IM,
    AD_DEN
  } acc_dst_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MUL,
    S_DIVP,
    S_DRAIN,
    S_MFIN,
    S_DCHK,
    S_DIV,
    S_DFIN,
    S_ADD,
    S_ZERO,
    S_OUT
  } state_e;

  typedef struct packed {
    logic      load;
    logic      issue;
    prod_sel_e sel;
    acc_dst_e  dst;
    logic      acc_first;
    logic      acc_sub;
    logic      mul_wb;
    logic      add_wb;
    logic      zero_wb;
    logic      div_init;
    logic      div_step;
    logic      div_wb;
  } cau_cmd_t;

  typedef struct packed {
    op_e  op;
    logic exp_none;
    logic exp_last;
    logic den_zero;
  } cau_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cau_if.sv =====
// Complex arithmetic unit: valid/ready channel interfaces for input and result words.
// Depends on cau_pkg.
`default_nettype none

interface cau_in_if;
  logic                           valid;
  logic                           ready;
  logic [cau_pkg::CMD_W-1:0]      cmd;
  logic signed [cau_pkg::DW-1:0]  a_re;
  logic signed [cau_pkg::DW-1:0]  a_im;
  logic signed [cau_pkg::DW-1:0]  b_re;
  logic signed [cau_pkg::DW-1:0]  b_im;
  logic [cau_pkg::EXP_W-1:0]      power_exponent;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, power_exponent, input ready);
  modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, power_exponent, output ready);
endinterface

interface cau_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [cau_pkg::DW-1:0]  res_re;
  logic signed [cau_pkg::DW-1:0]  res_im;
  logic [cau_pkg::STS_W-1:0]      status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cau_ctrl.sv =====
// Complex arithmetic unit: sequencing state machine.
// Depends on cau_pkg; drives cau_datapath through cau_cmd_t.
`default_nettype none

module cau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cau_pkg::cau_sts_t sts_i,
  output cau_pkg::cau_cmd_t cmd_o
);

  cau_pkg::state_e               state_q, state_d;
  logic [cau_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cau_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      cau_pkg::S_IDLE: begin
        if (in_valid_i) state_d = cau_pkg::S_DISP;
      end
      cau_pkg::S_DISP: begin
        cnt_d = '0;
        case (sts_i.op)
          cau_pkg::OP_ADD, cau_pkg::OP_SUB: state_d = cau_pkg::S_ADD;
          cau_pkg::OP_MUL: state_d = cau_pkg::S_MUL;
          cau_pkg::OP_DIV: state_d = cau_pkg::S_DIVP;
          cau_pkg::OP_POW: state_d = sts_i.exp_none ? cau_pkg::S_OUT : cau_pkg::S_MUL;
          default: state_d = cau_pkg::S_ZERO;
        endcase
      end
      cau_pkg::S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cau_pkg::CNT_W'(3)) state_d = cau_pkg::S_DRAIN;
      end
      cau_pkg::S_DIVP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cau_pkg::CNT_W'(5)) state_d = cau_pkg::S_DRAIN;
      end
      cau_pkg::S_DRAIN: begin
        state_d = (sts_i.op == cau_pkg::OP_DIV) ? cau_pkg::S_DCHK : cau_pkg::S_MFIN;
      end
      cau_pkg::S_MFIN: begin
        cnt_d = '0;
        if (sts_i.op == cau_pkg::OP_POW && !sts_i.exp_last) state_d = cau_pkg::S_MUL;
        else state_d = cau_pkg::S_OUT;
      end
      cau_pkg::S_DCHK: begin
        cnt_d   = '0;
        state_d = sts_i.den_zero ? cau_pkg::S_ZERO : cau_pkg::S_DIV;
      end
      cau_pkg::S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cau_pkg::CNT_W'(cau_pkg::DW - 1)) state_d = cau_pkg::S_DFIN;
      end
      cau_pkg::S_DFIN, cau_pkg::S_ADD, cau_pkg::S_ZERO: state_d = cau_pkg::S_OUT;
      cau_pkg::S_OUT: begin
        if (out_ready_i) state_d = cau_pkg::S_IDLE;
      end
      default: state_d = cau_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      cau_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cau_pkg::S_MUL: begin
        cmd_o.issue = 1'b1;
        case (cnt_q)
          cau_pkg::CNT_W'(0): begin
            cmd_o.sel = cau_pkg::PS_RR; cmd_o.dst = cau_pkg::AD_RE; cmd_o.acc_first = 1'b1;
          end
          cau_pkg::CNT_W'(1): begin
            cmd_o.sel = cau_pkg::PS_II; cmd_o.dst = cau_pkg::AD_RE; cmd_o.acc_sub = 1'b1;
          end
          cau_pkg::CNT_W'(2): begin
            cmd_o.sel = cau_pkg::PS_RI; cmd_o.dst = cau_pkg::AD_IM; cmd_o.acc_first = 1'b1;
          end
          default: begin
            cmd_o.sel = cau_pkg::PS_IR; cmd_o.dst = cau_pkg::AD_IM;
          end
        endcase
      end
      cau_pkg::S_DIVP: begin
        cmd_o.issue = 1'b1;
        case (cnt_q)
          cau_pkg::CNT_W'(0): begin
            cmd_o.sel = cau_pkg::PS_RR; cmd_o.dst = cau_pkg::AD_RE; cmd_o.acc_first = 1'b1;
          end
          cau_pkg::CNT_W'(1): begin
            cmd_o.sel = cau_pkg::PS_II; cmd_o.dst = cau_pkg::AD_RE;
          end
          cau_pkg::CNT_W'(2): begin
            cmd_o.sel = cau_pkg::PS_IR; cmd_o.dst = cau_pkg::AD_IM; cmd_o.acc_first = 1'b1;
          end
          cau_pkg::CNT_W'(3): begin
            cmd_o.sel = cau_pkg::PS_RI; cmd_o.dst = cau_pkg::AD_IM; cmd_o.acc_sub = 1'b1;
          end
          cau_pkg::CNT_W'(4): begin
            cmd_o.sel = cau_pkg::PS_YRR; cmd_o.dst = cau_pkg::AD_DEN; cmd_o.acc_first = 1'b1;
          end
          default: begin
            cmd_o.sel = cau_pkg::PS_YII; cmd_o.dst = cau_pkg::AD_DEN;
          end
        endcase
      end
      cau_pkg::S_MFIN: cmd_o.mul_wb = 1'b1;
      cau_pkg::S_DCHK: cmd_o.div_init = !sts_i.den_zero;
      cau_pkg::S_DIV:  cmd_o.div_step = 1'b1;
      cau_pkg::S_DFIN: cmd_o.div_wb = 1'b1;
      cau_pkg::S_ADD:  cmd_o.add_wb = 1'b1;
      cau_pkg::S_ZERO: cmd_o.zero_wb = 1'b1;
      cau_pkg::S_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_datapath.sv =====
// Complex arithmetic unit: operand registers, shared multiplier, accumulators,
// two-lane restoring divider and saturation. Depends on cau_pkg.
`default_nettype none

module cau_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cau_pkg::cau_cmd_t             cmd_i,
  output cau_pkg::cau_sts_t             sts_o,
  input  logic [cau_pkg::CMD_W-1:0]     op_i,
  input  logic signed [cau_pkg::DW-1:0] a_re_i,
  input  logic signed [cau_pkg::DW-1:0] a_im_i,
  input  logic signed [cau_pkg::DW-1:0] b_re_i,
  input  logic signed [cau_pkg::DW-1:0] b_im_i,
  input  logic [cau_pkg::EXP_W-1:0]     exp_i,
  output logic signed [cau_pkg::DW-1:0] res_re_o,
  output logic signed [cau_pkg::DW-1:0] res_im_o,
  output logic [cau_pkg::STS_W-1:0]     status_o
);

  localparam int DW    = cau_pkg::DW;
  localparam int FW    = cau_pkg::FW;
  localparam int ACC_W = cau_pkg::ACC_W;
  localparam int DEN_W = cau_pkg::DEN_W;
  localparam int IW    = DW - FW;
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};

  function automatic logic [DW:0] fix_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic [ACC_W-FW-1:0]     q;
    logic                    ovf;
    t   = v + $signed({{(ACC_W-FW){1'b0}}, {FW{v[ACC_W-1]}}});
    q   = t[ACC_W-1:FW];
    ovf = (q[ACC_W-FW-1:DW-1] != '0) && (q[ACC_W-FW-1:DW-1] != '1);
    return ovf ? {1'b1, (q[ACC_W-FW-1] ? MINV : MAXV)} : {1'b0, q[DW-1:0]};
  endfunction

  function automatic logic [DW:0] sum_sat(input logic [DW+1:0] s);
    logic ovf;
    ovf = (s[DW+1:DW-1] != '0) && (s[DW+1:DW-1] != '1);
    return ovf ? {1'b1, (s[DW+1] ? MINV : MAXV)} : {1'b0, s[DW-1:0]};
  endfunction

  function automatic logic [DEN_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    return m[DEN_W-1:0];
  endfunction

  function automatic logic [DW:0] div_fin(input logic neg, input logic big,
                                          input logic [DW-1:0] q);
    logic ovf;
    ovf = big | (q[DW-1] & (!neg | (q[DW-2:0] != '0)));
    return ovf ? {1'b1, (neg ? MINV : MAXV)} : {1'b0, (neg ? DW'(-q) : q)};
  endfunction

  cau_pkg::op_e                op_q;
  logic signed [DW-1:0]        x_re_q, x_im_q, y_re_q, y_im_q;
  logic [cau_pkg::REM_W-1:0]   exp_q;
  logic                        ovf_q, dz_q;
  logic signed [2*DW-1:0]      prod_q;
  logic                        pv_q, pfirst_q, psub_q;
  cau_pkg::acc_dst_e           pdst_q;
  logic signed [ACC_W-1:0]     acc_re_q, acc_im_q;
  logic [DEN_W-1:0]            den_q;
  logic [DEN_W-1:0]            rem_re_q, rem_im_q;
  logic [DW-1:0]               sh_re_q, sh_im_q;
  logic                        big_re_q, big_im_q, neg_re_q, neg_im_q;

  logic signed [DW-1:0]        m1, m2;
  logic signed [ACC_W-1:0]     pext, padd;
  logic [DW:0]                 fs_re, fs_im, as_re, as_im, df_re, df_im;
  logic [DW+1:0]               s_re, s_im;
  logic [DEN_W-1:0]            mg_re, mg_im;
  logic [DEN_W:0]              t_re, t_im, d_re, d_im;
  logic                        ge_re, ge_im;
  logic [cau_pkg::EXP_W-1:0]   e_cl;

  always_comb begin
    case (cmd_i.sel)
      cau_pkg::PS_RR:  begin m1 = x_re_q; m2 = y_re_q; end
      cau_pkg::PS_II:  begin m1 = x_im_q; m2 = y_im_q; end
      cau_pkg::PS_RI:  begin m1 = x_re_q; m2 = y_im_q; end
      cau_pkg::PS_IR:  begin m1 = x_im_q; m2 = y_re_q; end
      cau_pkg::PS_YRR: begin m1 = y_re_q; m2 = y_re_q; end
      cau_pkg::PS_YII: begin m1 = y_im_q; m2 = y_im_q; end
      default:         begin m1 = x_re_q; m2 = y_re_q; end
    endcase
  end

  assign pext = {{(ACC_W-2*DW){prod_q[2*DW-1]}}, prod_q};
  assign padd = psub_q ? -pext : pext;

  assign fs_re = fix_sat(acc_re_q);
  assign fs_im = fix_sat(acc_im_q);

  assign s_re  = (op_q == cau_pkg::OP_SUB)
               ? {{2{x_re_q[DW-1]}}, x_re_q} - {{2{y_re_q[DW-1]}}, y_re_q}
               : {{2{x_re_q[DW-1]}}, x_re_q} + {{2{y_re_q[DW-1]}}, y_re_q};
  assign s_im  = (op_q == cau_pkg::OP_SUB)
               ? {{2{x_im_q[DW-1]}}, x_im_q} - {{2{y_im_q[DW-1]}}, y_im_q}
               : {{2{x_im_q[DW-1]}}, x_im_q} + {{2{y_im_q[DW-1]}}, y_im_q};
  assign as_re = sum_sat(s_re);
  assign as_im = sum_sat(s_im);

  assign mg_re = mag(acc_re_q);
  assign mg_im = mag(acc_im_q);

  assign t_re  = {rem_re_q, sh_re_q[DW-1]};
  assign t_im  = {rem_im_q, sh_im_q[DW-1]};
  assign d_re  = t_re - {1'b0, den_q};
  assign d_im  = t_im - {1'b0, den_q};
  assign ge_re = t_re >= {1'b0, den_q};
  assign ge_im = t_im >= {1'b0, den_q};

  assign df_re = div_fin(neg_re_q, big_re_q, sh_re_q);
  assign df_im = div_fin(neg_im_q, big_im_q, sh_im_q);

  assign e_cl = (exp_i == '0) ? cau_pkg::EXP_W'(1)
              : (exp_i > cau_pkg::EXP_W'(cau_pkg::MAX_EXP)) ? cau_pkg::EXP_W'(cau_pkg::MAX_EXP)
              : exp_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= cau_pkg::OP_ADD;
      exp_q <= '0;
      ovf_q <= 1'b0;
      dz_q  <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
      if (cmd_i.load) begin
        op_q  <= cau_pkg::op_e'(op_i);
        exp_q <= cau_pkg::REM_W'(e_cl - 1'b1);
        ovf_q <= 1'b0;
        dz_q  <= 1'b0;
      end
      if (cmd_i.mul_wb) begin
        ovf_q <= ovf_q | fs_re[DW] | fs_im[DW];
        if (exp_q != '0) exp_q <= exp_q - 1'b1;
      end
      if (cmd_i.add_wb) ovf_q <= as_re[DW] | as_im[DW];
      if (cmd_i.div_wb) ovf_q <= df_re[DW] | df_im[DW];
      if (cmd_i.zero_wb) dz_q <= (op_q == cau_pkg::OP_DIV);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_re_q <= a_re_i;
      x_im_q <= a_im_i;
      y_re_q <= (cau_pkg::op_e'(op_i) == cau_pkg::OP_POW) ? a_re_i : b_re_i;
      y_im_q <= (cau_pkg::op_e'(op_i) == cau_pkg::OP_POW) ? a_im_i : b_im_i;
    end
    if (cmd_i.mul_wb) begin
      x_re_q <= fs_re[DW-1:0];
      x_im_q <= fs_im[DW-1:0];
    end
    if (cmd_i.add_wb) begin
      x_re_q <= as_re[DW-1:0];
      x_im_q <= as_im[DW-1:0];
    end
    if (cmd_i.div_wb) begin
      x_re_q <= df_re[DW-1:0];
      x_im_q <= df_im[DW-1:0];
    end
    if (cmd_i.zero_wb) begin
      x_re_q <= '0;
      x_im_q <= '0;
    end
    if (cmd_i.issue) begin
      prod_q   <= m1 * m2;
      pdst_q   <= cmd_i.dst;
      pfirst_q <= cmd_i.acc_first;
      psub_q   <= cmd_i.acc_sub;
    end
    if (pv_q) begin
      case (pdst_q)
        cau_pkg::AD_RE:  acc_re_q <= pfirst_q ? padd : acc_re_q + padd;
        cau_pkg::AD_IM:  acc_im_q <= pfirst_q ? padd : acc_im_q + padd;
        default:         den_q <= pfirst_q ? DEN_W'(prod_q) : den_q + DEN_W'(prod_q);
      endcase
    end
    if (cmd_i.div_init) begin
      neg_re_q <= acc_re_q[ACC_W-1];
      neg_im_q <= acc_im_q[ACC_W-1];
      big_re_q <= {{IW{1'b0}}, mg_re} >= {den_q, {IW{1'b0}}};
      big_im_q <= {{IW{1'b0}}, mg_im} >= {den_q, {IW{1'b0}}};
      rem_re_q <= mg_re >> IW;
      rem_im_q <= mg_im >> IW;
      sh_re_q  <= {mg_re[IW-1:0], {FW{1'b0}}};
      sh_im_q  <= {mg_im[IW-1:0], {FW{1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_re_q <= ge_re ? d_re[DEN_W-1:0] : t_re[DEN_W-1:0];
      rem_im_q <= ge_im ? d_im[DEN_W-1:0] : t_im[DEN_W-1:0];
      sh_re_q  <= {sh_re_q[DW-2:0], ge_re};
      sh_im_q  <= {sh_im_q[DW-2:0], ge_im};
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.exp_none = (exp_q == '0);
  assign sts_o.exp_last = (exp_q == cau_pkg::REM_W'(1));
  assign sts_o.den_zero = (den_q == '0);

  assign res_re_o = x_re_q;
  assign res_im_o = x_im_q;
  assign status_o = dz_q  ? cau_pkg::ST_DIVZ
                  : ovf_q ? cau_pkg::ST_OVF
                  : cau_pkg::ST_OK;

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, one word at a time: add/sub, multiply, divide (32 restoring
// steps) and power by repeated multiply, with one shared 32x32 multiplier doing four
// products per complex multiply.
// The next word is taken in the cycle after the result word is taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; no result pending.
// Depends on cau_pkg, cau_if, cau_ctrl and cau_datapath.
`default_nettype none

module complex_arithmetic_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  cau_pkg::cau_cmd_t cmd;
  cau_pkg::cau_sts_t sts;

  cau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cau_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .op_i     (in_i.cmd),
    .a_re_i   (in_i.a_re),
    .a_im_i   (in_i.a_im),
    .b_re_i   (in_i.b_re),
    .b_im_i   (in_i.b_im),
    .exp_i    (in_i.power_exponent),
    .res_re_o (out_o.res_re),
    .res_im_o (out_o.res_im),
    .status_o (out_o.status)
  );

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result word is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second word accepted back to back");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status != 2'd3))
    else $error("illegal status code");

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == cau_pkg::ST_DIVZ) |->
      (out_o.res_re == '0 && out_o.res_im == '0))
    else $error("divide by zero result not cleared");
`endif

endmodule

`default_nettype wire

// ===== verif/cau_tb_if.sv =====
// Complex arithmetic unit testbench: holds no interfaces of its own; the block's
// cau_in_if and cau_out_if channels are used directly. Depends on cau_pkg.
`timescale 1ns / 100ps

package cau_tb_pkg;
  import cau_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic signed [DW-1:0]  a_re;
    logic signed [DW-1:0]  a_im;
    logic signed [DW-1:0]  b_re;
    logic signed [DW-1:0]  b_im;
    logic [EXP_W-1:0]      pexp;
  } cau_word_t;

  typedef struct packed {
    logic signed [DW-1:0]  re;
    logic signed [DW-1:0]  im;
    logic [STS_W-1:0]      sts;
  } cau_res_t;
endpackage

// ===== verif/complex_arithmetic_unit_tb.sv =====
// Complex arithmetic unit testbench: directed table then bursty random words, checked
// against table values or an in-bench fixed-point predictor. Depends on cau_pkg, cau_if.
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;
  import cau_tb_pkg::*;

  localparam int N_RAND    = 1800;
  localparam int LIMIT_CYC = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  localparam logic signed [127:0] SMAX = (128'sd1 <<< (DW - 1)) - 1;
  localparam logic signed [127:0] SMIN = -(128'sd1 <<< (DW - 1));

  cau_res_t  expected_q[$];
  int        n_mism = 0, n_res = 0, n_words = 0, cyc = 0;
  logic      hold_off = 1'b0;
  logic      sending_done = 1'b0;
  int        op_seen[8];

  function automatic logic signed [127:0] clamp(input logic signed [127:0] v, inout logic ovf);
    if (v > SMAX) begin
      ovf = 1'b1;
      return SMAX;
    end
    if (v < SMIN) begin
      ovf = 1'b1;
      return SMIN;
    end
    return v;
  endfunction

  // truncate toward zero
  function automatic logic signed [127:0] tshr(input logic signed [127:0] v);
    if (v < 0) return -((-v) >>> FW);
    return v >>> FW;
  endfunction

  function automatic void cmult(input logic signed [127:0] ar, ai, br, bi,
                                output logic signed [127:0] rr, ri, inout logic ovf);
    rr = clamp(tshr(ar * br - ai * bi), ovf);
    ri = clamp(tshr(ar * bi + ai * br), ovf);
  endfunction

  function automatic logic signed [127:0] qdiv(input logic signed [127:0] num, den,
                                                inout logic ovf);
    logic signed [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FW) / den;
    return clamp((num < 0) ? -q : q, ovf);
  endfunction

  function automatic cau_res_t complex_result(input cau_word_t w);
    logic signed [127:0] ar, ai, br, bi, rr, ri, tr, ti, den;
    logic ovf;
    int e;
    cau_res_t r;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    rr = 0; ri = 0; ovf = 1'b0;
    r.sts = ST_OK;
    case (w.cmd)
      OP_ADD: begin
        rr = clamp(ar + br, ovf);
        ri = clamp(ai + bi, ovf);
      end
      OP_SUB: begin
        rr = clamp(ar - br, ovf);
        ri = clamp(ai - bi, ovf);
      end
      OP_MUL: cmult(ar, ai, br, bi, rr, ri, ovf);
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.sts = ST_DIVZ;
        else begin
          rr = qdiv(ar * br + ai * bi, den, ovf);
          ri = qdiv(ai * br - ar * bi, den, ovf);
        end
      end
      OP_POW: begin
        e = w.pexp;
        if (e < 1) e = 1;
        if (e > MAX_EXP) e = MAX_EXP;
        rr = ar; ri = ai;
        for (int n = 1; n < e; n++) begin
          cmult(rr, ri, ar, ai, tr, ti, ovf);
          rr = tr; ri = ti;
        end
      end
      default: ;
    endcase
    if (ovf && r.sts == ST_OK) r.sts = ST_OVF;
    r.re = rr[DW-1:0];
    r.im = ri[DW-1:0];
    return r;
  endfunction

  typedef struct {
    cau_word_t w;
    logic      typed;
    cau_res_t  r;
  } dir_row_t;

  localparam logic [DW-1:0] MAXW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINW = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE  = 1 << FW;
  dir_row_t dir_tab[$];

  function automatic dir_row_t row(input logic [2:0] c, input logic [DW-1:0] ar, ai, br, bi,
                                   input logic [4:0] e, input logic t,
                                   input logic [DW-1:0] rr, ri, input logic [1:0] s);
    dir_row_t d;
    d.w = '{c, ar, ai, br, bi, e};
    d.typed = t;
    d.r = '{rr, ri, s};
    return d;
  endfunction

  initial begin
    dir_tab.push_back(row(OP_ADD, 0, 0, 0, 0, 0, 1, 0, 0, ST_OK));
    dir_tab.push_back(row(OP_ADD, MAXW, MINW, MAXW, MINW, 0, 1, MAXW, MINW, ST_OVF));
    dir_tab.push_back(row(OP_SUB, MINW, MAXW, 1, '1, 31, 1, MINW, MAXW, ST_OVF));
    dir_tab.push_back(row(OP_SUB, MAXW, MINW, MAXW, MINW, 7, 1, 0, 0, ST_OK));
    dir_tab.push_back(row(OP_MUL, ONE, 0, ONE, 0, 0, 1, ONE, 0, ST_OK));
    dir_tab.push_back(row(OP_MUL, MAXW, MAXW, MAXW, MINW, 3, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MUL, MINW, MINW, MINW, MINW, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_MUL, '1, 1, 1, '1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_DIV, MAXW, MINW, 0, 0, 0, 1, 0, 0, ST_DIVZ));
    dir_tab.push_back(row(OP_DIV, ONE, ONE, ONE, 0, 0, 1, ONE, ONE, ST_OK));
    dir_tab.push_back(row(OP_DIV, MAXW, MAXW, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_DIV, MINW, MINW, MINW, MINW, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_DIV, 12345, -999, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_POW, ONE, ONE, MAXW, MAXW, 0, 1, ONE, ONE, ST_OK));
    dir_tab.push_back(row(OP_POW, ONE, 0, 0, 0, 31, 1, ONE, 0, ST_OK));
    dir_tab.push_back(row(OP_POW, 0, ONE, 0, 0, 2, 1, -ONE, 0, ST_OK));
    dir_tab.push_back(row(OP_POW, MAXW, MINW, 0, 0, 16, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_POW, ONE + (ONE >> 1), ONE >> 2, 0, 0, 17, 0, 0, 0, 0));
    dir_tab.push_back(row(OP_POW, -ONE, 0, 0, 0, 15, 1, -ONE, 0, ST_OK));
    dir_tab.push_back(row(3'd5, MAXW, MAXW, MAXW, MAXW, 31, 1, 0, 0, ST_OK));
    dir_tab.push_back(row(3'd6, MINW, MINW, 1, 1, 0, 1, 0, 0, ST_OK));
    dir_tab.push_back(row(3'd7, '1, '1, '1, '1, 16, 1, 0, 0, ST_OK));
  end

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXW : MINW;
      2: return $signed($urandom_range(0, 8 << FW)) - $signed(32'(4 << FW));
      3: return $signed($urandom_range(0, ONE << 1)) - $signed(ONE);
      4: return $urandom_range(0, 3) - 1;
      default: return $signed($urandom_range(0, 1 << 20)) - $signed(32'(1 << 19));
    endcase
  endfunction

  function automatic cau_word_t rand_word();
    cau_word_t w;
    w.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    w.a_re = rand_operand();
    w.a_im = rand_operand();
    w.b_re = ($urandom_range(0, 15) == 0) ? '0 : rand_operand();
    w.b_im = ($urandom_range(0, 15) == 0) ? '0 : rand_operand();
    if (w.cmd == OP_POW) begin
      // keep the base near the unit circle so deep powers do not all saturate
      if ($urandom_range(0, 2) != 0) begin
        w.a_re = $signed($urandom_range(0, ONE << 1)) - $signed(ONE);
        w.a_im = $signed($urandom_range(0, ONE >> 1)) - $signed(ONE >> 2);
      end
      w.pexp = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
    end else begin
      w.pexp = EXP_W'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(input cau_word_t w, input logic typed, input cau_res_t r);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= w.cmd;
    in_ch.a_re <= w.a_re;
    in_ch.a_im <= w.a_im;
    in_ch.b_re <= w.b_re;
    in_ch.b_im <= w.b_im;
    in_ch.power_exponent <= w.pexp;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(typed ? r : complex_result(w));
    op_seen[w.cmd]++;
    n_words++;
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(1, 6);
    in_ch.valid <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  // sender
  initial begin
    int burst;
    cau_res_t dummy;
    dummy = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.a_re = '0;
    in_ch.a_im = '0;
    in_ch.b_re = '0;
    in_ch.b_im = '0;
    in_ch.power_exponent = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);
      if ($urandom_range(0, 1)) idle_gap();
    end
    while (n_words < dir_tab.size() + N_RAND) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_word(rand_word(), 1'b0, dummy);
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    in_ch.valid <= 1'b0;
    sending_done <= 1'b1;
  end

  // receiver stall pattern, with one long hold-off mid-run
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) out_ch.ready <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ((phase % 7) < 3) || ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (n_words > 600);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    cau_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_res++;
      if (expected_q.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected result word re=%h im=%h sts=%0d",
                                   out_ch.res_re, out_ch.res_im, out_ch.status);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.res_re !== want.re || out_ch.res_im !== want.im ||
            out_ch.status !== want.sts) begin
          n_mism++;
          if (n_mism <= 10)
            $display("mismatch word %0d: exp re=%h im=%h sts=%0d got re=%h im=%h sts=%0d",
                     n_res, want.re, want.im, want.sts,
                     out_ch.res_re, out_ch.res_im, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d words outstanding", cyc, expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("%0d words sent, %0d results checked in %0d cycles", n_words, n_res, cyc);
    $display("ops add %0d sub %0d mul %0d div %0d pow %0d unused %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (n_mism == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_mism);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
